// ===== rtl/psat_pkg.sv =====
// Package for the polygon separating-axis overlap block.
// Holds the command codes, the decoded operation type and the queued transaction type.
// Depends on nothing; every other file refers to it by scoped names.
package psat_pkg;

    // Coordinate width, signed fixed point with four fraction bits.
    localparam int COORD_W = 16;
    // Width of a coordinate difference.
    localparam int DIFF_W = COORD_W + 1;
    // Width of one product of two differences.
    localparam int PROD_W = 2 * DIFF_W;

    // Raw command codes on the input port.
    localparam logic [1:0] CMD_CLEAR    = 2'd0;
    localparam logic [1:0] CMD_APPEND_A = 2'd1;
    localparam logic [1:0] CMD_APPEND_B = 2'd2;
    localparam logic [1:0] CMD_TEST     = 2'd3;

    // Queue between the front and the back.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    // Decoded operation carried to the back.
    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_APPEND_A,
        OP_APPEND_B,
        OP_TEST
    } t_op;

    // One stored vertex.
    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_vert;

    // One queued transaction.
    typedef struct packed {
        t_op   op;
        t_vert vert;
    } t_item;

endpackage

// ===== rtl/psat_front.sv =====
// Front stage: accepts command transactions and decodes them into queue items.
// Depends on psat_pkg for the command codes and the item type.
module psat_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_command,
    input  logic signed [psat_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [psat_pkg::COORD_W-1:0] i_coord_y,
    input  logic                            i_q_full,
    output logic                            o_push,
    output psat_pkg::t_item                 o_item
);

    logic            r_vld;
    psat_pkg::t_item r_item;
    psat_pkg::t_item n_item;
    logic            accept;

    // The held item blocks new transactions only while the queue is full.
    assign busy   = r_vld && i_q_full;
    assign accept = start && !busy;
    assign o_push = r_vld && !i_q_full;
    assign o_item = r_item;

    // Decode the raw command into an operation.
    always_comb begin
        n_item.vert.x = i_coord_x;
        n_item.vert.y = i_coord_y;
        unique case (i_command)
            psat_pkg::CMD_CLEAR:    n_item.op = psat_pkg::OP_CLEAR;
            psat_pkg::CMD_APPEND_A: n_item.op = psat_pkg::OP_APPEND_A;
            psat_pkg::CMD_APPEND_B: n_item.op = psat_pkg::OP_APPEND_B;
            psat_pkg::CMD_TEST:     n_item.op = psat_pkg::OP_TEST;
            default:                n_item.op = psat_pkg::OP_TEST;
        endcase
    end

    // Valid flag of the holding register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    // Payload of the holding register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== rtl/psat_queue.sv =====
// Short first-in first-out queue of decoded items between the front and the back.
// Depends on psat_pkg for the item type and the queue size.
module psat_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  psat_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output psat_pkg::t_item o_item
);

    psat_pkg::t_item                r_mem [psat_pkg::Q_DEPTH];
    logic [psat_pkg::Q_AW-1:0]      r_wr_ptr;
    logic [psat_pkg::Q_AW-1:0]      r_rd_ptr;
    logic [psat_pkg::Q_CW-1:0]      r_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_full  = (r_count == psat_pkg::Q_CW'(psat_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== rtl/psat_back.sv =====
// Back end: executes clears and appends and runs the separating-axis test.
// Holds both vertex memories and the edge sequencer; depends on psat_pkg.
module psat_back #(
    parameter int MAX_VERTICES = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  psat_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_valid,
    output logic            o_colliding,
    output logic            o_dropped
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int CW_ = psat_pkg::COORD_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EDGE_RD,
        S_EDGE_CALC,
        S_SCAN
    } t_state;

    t_state r_state;

    // Vertex memories with two registered read ports each.
    psat_pkg::t_vert r_mem_a [MAX_VERTICES];
    psat_pkg::t_vert r_mem_b [MAX_VERTICES];
    psat_pkg::t_vert r_rd0_a;
    psat_pkg::t_vert r_rd1_a;
    psat_pkg::t_vert r_rd0_b;
    psat_pkg::t_vert r_rd1_b;

    logic [CW-1:0] r_cnt_a;
    logic [CW-1:0] r_cnt_b;
    logic          r_ovf;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_j;
    logic          r_dir;
    logic          r_allpos;
    logic          r_v1;
    logic          r_v2;
    logic          r_v3;
    logic          r_out_valid;
    logic          r_colliding;
    logic          r_dropped;

    // Edge and scan datapath registers.
    logic signed [CW_-1:0]                  r_ax;
    logic signed [CW_-1:0]                  r_ay;
    logic signed [psat_pkg::DIFF_W-1:0]     r_dx;
    logic signed [psat_pkg::DIFF_W-1:0]     r_dy;
    logic signed [psat_pkg::DIFF_W-1:0]     r_ex;
    logic signed [psat_pkg::DIFF_W-1:0]     r_ey;
    logic signed [psat_pkg::PROD_W-1:0]     r_p1;
    logic signed [psat_pkg::PROD_W-1:0]     r_p2;

    logic [CW-1:0]           np;
    logic [CW-1:0]           nq;
    logic [CW-1:0]           i_next;
    logic [CW-1:0]           nx;
    logic [AW-1:0]           addr0;
    logic [AW-1:0]           addr1;
    logic                    issue;
    logic                    drained;
    logic                    wr_a;
    logic                    wr_b;
    logic                    full_a;
    logic                    full_b;
    psat_pkg::t_vert         p0;
    psat_pkg::t_vert         p1;
    psat_pkg::t_vert         qv;
    logic signed [psat_pkg::PROD_W:0] dot;
    logic                    dot_pos;

    // Polygon roles: direction zero tests edges of A against vertices of B.
    assign np     = r_dir ? r_cnt_b : r_cnt_a;
    assign nq     = r_dir ? r_cnt_a : r_cnt_b;
    assign i_next = r_i + 1'b1;
    assign nx     = (i_next == np) ? '0 : i_next;

    // Read addresses: port 0 takes the edge start or the scanned vertex.
    assign addr0 = (r_state == S_EDGE_RD) ? r_i[AW-1:0] : r_j[AW-1:0];
    assign addr1 = nx[AW-1:0];

    assign issue   = (r_state == S_SCAN) && (r_j != nq);
    assign drained = (r_state == S_SCAN) && !issue && !r_v1 && !r_v2 && !r_v3;

    // Appends and the queue pop happen only in idle.
    assign o_pop  = (r_state == S_IDLE) && !i_empty;
    assign full_a = (r_cnt_a == CW'(MAX_VERTICES));
    assign full_b = (r_cnt_b == CW'(MAX_VERTICES));
    assign wr_a   = o_pop && (i_item.op == psat_pkg::OP_APPEND_A) && !full_a;
    assign wr_b   = o_pop && (i_item.op == psat_pkg::OP_APPEND_B) && !full_b;

    // Operand selection from the read ports.
    assign p0 = r_dir ? r_rd0_b : r_rd0_a;
    assign p1 = r_dir ? r_rd1_b : r_rd1_a;
    assign qv = r_dir ? r_rd0_a : r_rd0_b;

    // Final dot product and its sign.
    assign dot     = $signed({r_p1[psat_pkg::PROD_W-1], r_p1})
                   - $signed({r_p2[psat_pkg::PROD_W-1], r_p2});
    assign dot_pos = !dot[psat_pkg::PROD_W] && (dot != '0);

    assign o_valid     = r_out_valid;
    assign o_colliding = r_colliding;
    assign o_dropped   = r_dropped;

    // Memory of polygon A.
    always_ff @(posedge i_clk) begin
        if (wr_a) begin
            r_mem_a[r_cnt_a[AW-1:0]] <= i_item.vert;
        end
        r_rd0_a <= r_mem_a[addr0];
        r_rd1_a <= r_mem_a[addr1];
    end

    // Memory of polygon B.
    always_ff @(posedge i_clk) begin
        if (wr_b) begin
            r_mem_b[r_cnt_b[AW-1:0]] <= i_item.vert;
        end
        r_rd0_b <= r_mem_b[addr0];
        r_rd1_b <= r_mem_b[addr1];
    end

    // Edge setup and the three-stage dot product pipeline.
    always_ff @(posedge i_clk) begin
        if (r_state == S_EDGE_CALC) begin
            r_ax <= p0.x;
            r_ay <= p0.y;
            r_dx <= $signed({p1.x[CW_-1], p1.x}) - $signed({p0.x[CW_-1], p0.x});
            r_dy <= $signed({p1.y[CW_-1], p1.y}) - $signed({p0.y[CW_-1], p0.y});
        end
        if (r_v1) begin
            r_ex <= $signed({qv.x[CW_-1], qv.x}) - $signed({r_ax[CW_-1], r_ax});
            r_ey <= $signed({qv.y[CW_-1], qv.y}) - $signed({r_ay[CW_-1], r_ay});
        end
        if (r_v2) begin
            r_p1 <= r_ex * r_dy;
            r_p2 <= r_ey * r_dx;
        end
    end

    // Sequencer, counts, drop flag and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_ovf       <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_dir       <= 1'b0;
            r_allpos    <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
            r_colliding <= 1'b0;
            r_dropped   <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            r_v1        <= issue;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        unique case (i_item.op)
                            psat_pkg::OP_CLEAR: begin
                                r_cnt_a <= '0;
                                r_cnt_b <= '0;
                                r_ovf   <= 1'b0;
                            end
                            psat_pkg::OP_APPEND_A: begin
                                if (full_a) begin
                                    r_ovf <= 1'b1;
                                end else begin
                                    r_cnt_a <= r_cnt_a + 1'b1;
                                end
                            end
                            psat_pkg::OP_APPEND_B: begin
                                if (full_b) begin
                                    r_ovf <= 1'b1;
                                end else begin
                                    r_cnt_b <= r_cnt_b + 1'b1;
                                end
                            end
                            psat_pkg::OP_TEST: begin
                                // An empty polygon decides the test without a scan.
                                if (r_cnt_a == '0 || r_cnt_b == '0) begin
                                    r_out_valid <= 1'b1;
                                    r_colliding <= (r_cnt_a == '0) && (r_cnt_b == '0);
                                    r_dropped   <= r_ovf;
                                end else begin
                                    r_dir   <= 1'b0;
                                    r_i     <= '0;
                                    r_state <= S_EDGE_RD;
                                end
                            end
                            default: begin
                                r_ovf <= r_ovf;
                            end
                        endcase
                    end
                end
                S_EDGE_RD: begin
                    r_state <= S_EDGE_CALC;
                end
                S_EDGE_CALC: begin
                    r_j      <= '0;
                    r_allpos <= 1'b1;
                    r_state  <= S_SCAN;
                end
                S_SCAN: begin
                    if (issue) begin
                        r_j <= r_j + 1'b1;
                    end
                    if (r_v3 && !dot_pos) begin
                        r_allpos <= 1'b0;
                    end
                    if (drained) begin
                        if (r_allpos) begin
                            // This edge separates the polygons.
                            r_out_valid <= 1'b1;
                            r_colliding <= 1'b0;
                            r_dropped   <= r_ovf;
                            r_state     <= S_IDLE;
                        end else if (i_next != np) begin
                            r_i     <= i_next;
                            r_state <= S_EDGE_RD;
                        end else if (!r_dir) begin
                            r_dir   <= 1'b1;
                            r_i     <= '0;
                            r_state <= S_EDGE_RD;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_colliding <= 1'b1;
                            r_dropped   <= r_ovf;
                            r_state     <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/polygon_sat_overlap_test_top.sv =====
// Separating-axis overlap test for two convex polygons, top level.
// A test on an empty polygon is answered from idle without a scan; otherwise the back end
// examines the edges of A and then of B, and stops early when an edge separates.
// Clear and append transactions retire at one per cycle while the back end is not running a
// test; a test occupies the back end edge by edge in the single dot-product pipeline.
// Reset is synchronous and active low; results cannot be stalled by the receiver.
module polygon_sat_overlap_test_top #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_command,
    input  logic signed [psat_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [psat_pkg::COORD_W-1:0] i_coord_y,
    output logic                                o_valid,
    output logic                                o_colliding,
    output logic                                o_dropped
);

    logic            q_full;
    logic            q_empty;
    logic            push;
    logic            pop;
    psat_pkg::t_item push_item;
    psat_pkg::t_item pop_item;

    // Front: accept and decode transactions.
    psat_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_command (i_command),
        .i_coord_x (i_coord_x),
        .i_coord_y (i_coord_y),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_item    (push_item)
    );

    // Queue between front and back.
    psat_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_item  (pop_item)
    );

    // Back: vertex storage and the overlap test.
    psat_back #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_item      (pop_item),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .o_colliding (o_colliding),
        .o_dropped   (o_dropped)
    );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the polygon separating-axis overlap block.
// Predicts every test result from its own copy of both vertex stores and checks each strobe.
// Depends on psat_pkg and polygon_sat_overlap_test_top only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_VERTS    = 16;
    localparam int CYCLE_LIMIT  = 5_000_000;
    localparam int TAIL_CYCLES  = 1500;
    localparam int TARGET_ITEMS = 950;
    localparam int COORD_MAX    = 32767;

    // One predicted test outcome.
    typedef struct {
        logic colliding;
        logic dropped;
    } t_verdict;

    // Keeps both polygons, predicts test outcomes and checks the strobed results.
    class overlap_scoreboard;
        psat_pkg::t_vert poly_a[MAX_VERTS];
        psat_pkg::t_vert poly_b[MAX_VERTS];
        int       cnt_a;
        int       cnt_b;
        bit       drop_seen;
        t_verdict verdict_q[$];
        int       errors;

        function new();
            cnt_a     = 0;
            cnt_b     = 0;
            drop_seen = 1'b0;
            errors    = 0;
        endfunction

        // True when an edge of one polygon has every vertex of the other strictly outside.
        function bit has_separating_axis(bit from_a);
            psat_pkg::t_vert p[MAX_VERTS];
            psat_pkg::t_vert q[MAX_VERTS];
            int     np;
            int     nq;
            int     nxt;
            longint ax;
            longint ay;
            longint dx;
            longint dy;
            longint d;
            bit     all_outside;
            if (from_a) begin
                p  = poly_a;
                q  = poly_b;
                np = cnt_a;
                nq = cnt_b;
            end else begin
                p  = poly_b;
                q  = poly_a;
                np = cnt_b;
                nq = cnt_a;
            end
            for (int i = 0; i < np; i++) begin
                // An empty opposite polygon lies beyond every edge.
                if (nq == 0) return 1'b1;
                nxt = (i + 1 < np) ? i + 1 : 0;
                ax  = $signed(p[i].x);
                ay  = $signed(p[i].y);
                dx  = $signed(p[nxt].x) - ax;
                dy  = $signed(p[nxt].y) - ay;
                all_outside = 1'b1;
                for (int j = 0; j < nq; j++) begin
                    d = ($signed(q[j].x) - ax) * dy - ($signed(q[j].y) - ay) * dx;
                    if (d <= 0) all_outside = 1'b0;
                end
                if (all_outside) return 1'b1;
            end
            return 1'b0;
        endfunction

        // Applies one accepted transaction; returns 0 when the block merely drops it.
        function bit note_input(logic [1:0] cmd, logic signed [15:0] x, logic signed [15:0] y);
            psat_pkg::t_vert v;
            t_verdict        verdict;
            v.x = x;
            v.y = y;
            case (cmd)
                psat_pkg::CMD_CLEAR: begin
                    cnt_a     = 0;
                    cnt_b     = 0;
                    drop_seen = 1'b0;
                end
                psat_pkg::CMD_APPEND_A: begin
                    if (cnt_a < MAX_VERTS) begin
                        poly_a[cnt_a] = v;
                        cnt_a++;
                    end else begin
                        drop_seen = 1'b1;
                        return 1'b0;
                    end
                end
                psat_pkg::CMD_APPEND_B: begin
                    if (cnt_b < MAX_VERTS) begin
                        poly_b[cnt_b] = v;
                        cnt_b++;
                    end else begin
                        drop_seen = 1'b1;
                        return 1'b0;
                    end
                end
                default: begin
                    verdict.colliding = !(has_separating_axis(1'b1) ||
                                          has_separating_axis(1'b0));
                    verdict.dropped   = drop_seen;
                    verdict_q.push_back(verdict);
                end
            endcase
            return 1'b1;
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] ERROR: %s", $time, msg);
            errors++;
        endtask

        // Compares one strobed result with the oldest predicted outcome.
        task check_result(logic colliding, logic dropped);
            t_verdict want;
            if (verdict_q.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending (colliding %b dropped %b)",
                                          colliding, dropped));
            end else begin
                want = verdict_q.pop_front();
                if (colliding !== want.colliding)
                    report_mismatch($sformatf("colliding is %b, expected %b",
                                              colliding, want.colliding));
                if (dropped !== want.dropped)
                    report_mismatch($sformatf("dropped is %b, expected %b",
                                              dropped, want.dropped));
            end
        endtask
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          command;
    logic signed [15:0]  coord_x;
    logic signed [15:0]  coord_y;
    logic                o_valid;
    logic                o_colliding;
    logic                o_dropped;

    overlap_scoreboard   sb;
    int                  items_done;
    int                  cycles;
    bit                  burst_mode;

    polygon_sat_overlap_test_top #(
        .MAX_VERTICES(MAX_VERTS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_command   (command),
        .i_coord_x   (coord_x),
        .i_coord_y   (coord_y),
        .o_valid     (o_valid),
        .o_colliding (o_colliding),
        .o_dropped   (o_dropped)
    );

    // Free-running clock, 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Result monitor: a strobed result is taken at the edge that ends its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1) sb.check_result(o_colliding, o_dropped);
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Idle length before a transaction: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (burst_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [15:0] rand16();
        return 16'($urandom);
    endfunction

    // Raw coordinate with extra weight on both extremes.
    function automatic logic [15:0] pick_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h8000;
        if (r == 1) return 16'h7FFF;
        return rand16();
    endfunction

    // Center that keeps a circle of the given radius inside the coordinate range.
    function automatic int rand_center(int r);
        int lim;
        lim = COORD_MAX - r;
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    function automatic int clamp_center(int c, int r);
        if (c > COORD_MAX - r) return COORD_MAX - r;
        if (c < r - COORD_MAX) return r - COORD_MAX;
        return c;
    endfunction

    function automatic int pick_radius();
        if ($urandom_range(0, 7) == 0) return $urandom_range(2000, 16000);
        return $urandom_range(8, 1500);
    endfunction

    function automatic int pick_count();
        if ($urandom_range(0, 11) == 0) return MAX_VERTS;
        return $urandom_range(3, 6);
    endfunction

    // Presents one transaction and waits until the block takes it.
    task automatic send_item(logic [1:0] cmd, logic [15:0] x, logic [15:0] y);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        command <= cmd;
        coord_x <= x;
        coord_y <= y;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (sb.note_input(cmd, x, y)) items_done++;
    endtask

    // Holds off new transactions until every pending test result has arrived.
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.verdict_q.size() != 0);
    endtask

    // Appends a convex polygon: points on a circle in angular order.
    task automatic load_convex(logic [1:0] cmd, int n, int cx, int cy, int r, bit clockwise);
        real base;
        real step;
        real ang;
        int  idx;
        int  px;
        int  py;
        base = $urandom_range(0, 6283) / 1000.0;
        step = 6.283185307 / n;
        for (int k = 0; k < n; k++) begin
            idx = clockwise ? n - 1 - k : k;
            ang = base + step * (idx + $urandom_range(0, 40) / 100.0);
            px  = cx + $rtoi(r * $cos(ang));
            py  = cy + $rtoi(r * $sin(ang));
            send_item(cmd, 16'(px), 16'(py));
        end
    endtask

    // Two convex polygons placed near each other, so that about half of them overlap.
    task automatic run_overlap_pair(bit odd_winding);
        int na;
        int nb;
        int ra;
        int rb;
        int cxa;
        int cya;
        int cxb;
        int cyb;
        int spread;
        na     = pick_count();
        nb     = pick_count();
        ra     = pick_radius();
        rb     = pick_radius();
        cxa    = rand_center(ra);
        cya    = rand_center(ra);
        spread = (ra + rb) * 13 / 10;
        cxb    = clamp_center(cxa + int'($urandom_range(0, 2 * spread)) - spread, rb);
        cyb    = clamp_center(cya + int'($urandom_range(0, 2 * spread)) - spread, rb);
        send_item(psat_pkg::CMD_CLEAR, rand16(), rand16());
        load_convex(psat_pkg::CMD_APPEND_A, na, cxa, cya, ra,
                    odd_winding && $urandom_range(0, 1));
        load_convex(psat_pkg::CMD_APPEND_B, nb, cxb, cyb, rb,
                    odd_winding && $urandom_range(0, 1));
        send_item(psat_pkg::CMD_TEST, rand16(), rand16());
        if ($urandom_range(0, 3) == 0) send_item(psat_pkg::CMD_TEST, rand16(), rand16());
    endtask

    // A clear and a test on two empty polygons, then one polygon filled past capacity and tested against a small one.
    task automatic run_overflow();
        logic [1:0] full_side;
        logic [1:0] other_side;
        int         r;
        full_side  = $urandom_range(0, 1) ? psat_pkg::CMD_APPEND_A : psat_pkg::CMD_APPEND_B;
        other_side = (full_side == psat_pkg::CMD_APPEND_A) ? psat_pkg::CMD_APPEND_B
                                                           : psat_pkg::CMD_APPEND_A;
        r          = pick_radius();
        send_item(psat_pkg::CMD_CLEAR, rand16(), rand16());
        send_item(psat_pkg::CMD_TEST, rand16(), rand16());
        load_convex(full_side, MAX_VERTS, rand_center(r), rand_center(r), r, 1'b0);
        repeat ($urandom_range(1, 4)) send_item(full_side, pick_coord(), pick_coord());
        load_convex(other_side, $urandom_range(3, 5), rand_center(r), rand_center(r), r, 1'b0);
        send_item(psat_pkg::CMD_TEST, rand16(), rand16());
    endtask

    // Empty and tiny polygons of up to three points each, often on the same spot.
    task automatic run_tiny();
        int cx;
        int cy;
        cx = rand_center(4);
        cy = rand_center(4);
        send_item(psat_pkg::CMD_CLEAR, rand16(), rand16());
        repeat ($urandom_range(0, 3))
            send_item(psat_pkg::CMD_APPEND_A, 16'(cx + int'($urandom_range(0, 4)) - 2),
                      16'(cy + int'($urandom_range(0, 4)) - 2));
        repeat ($urandom_range(0, 3))
            send_item(psat_pkg::CMD_APPEND_B, 16'(cx + int'($urandom_range(0, 4)) - 2),
                      16'(cy + int'($urandom_range(0, 4)) - 2));
        send_item(psat_pkg::CMD_TEST, rand16(), rand16());
    endtask

    // Unstructured transactions with raw coordinates.
    task automatic run_noise();
        int         r;
        logic [1:0] cmd;
        repeat ($urandom_range(1, 12)) begin
            r = $urandom_range(0, 9);
            if (r == 0)     cmd = psat_pkg::CMD_CLEAR;
            else if (r < 5) cmd = psat_pkg::CMD_APPEND_A;
            else if (r < 8) cmd = psat_pkg::CMD_APPEND_B;
            else            cmd = psat_pkg::CMD_TEST;
            send_item(cmd, pick_coord(), pick_coord());
        end
    endtask

    // Stimulus: reset, directed corners, then random sequences.
    initial begin
        int kind;
        int seq_count;
        sb         = new();
        items_done = 0;
        cycles     = 0;
        seq_count  = 0;
        burst_mode = 1'b0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        command    = psat_pkg::CMD_CLEAR;
        coord_x    = '0;
        coord_y    = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Both empty, one empty, single points on the same spot.
        send_item(psat_pkg::CMD_TEST, 16'h7FFF, 16'h8000);
        send_item(psat_pkg::CMD_APPEND_A, 16'h8000, 16'h8000);
        send_item(psat_pkg::CMD_TEST, 16'h0000, 16'h0000);
        send_item(psat_pkg::CMD_APPEND_B, 16'h8000, 16'h8000);
        send_item(psat_pkg::CMD_TEST, 16'h8000, 16'h7FFF);
        // Full-range triangle against a segment and then a triangle on its corners.
        send_item(psat_pkg::CMD_APPEND_A, 16'h7FFF, 16'h8000);
        send_item(psat_pkg::CMD_APPEND_A, 16'h7FFF, 16'h7FFF);
        send_item(psat_pkg::CMD_APPEND_B, 16'h8000, 16'h7FFF);
        send_item(psat_pkg::CMD_TEST, 16'hFFFF, 16'hFFFF);
        send_item(psat_pkg::CMD_APPEND_B, 16'h7FFF, 16'h7FFF);
        send_item(psat_pkg::CMD_TEST, 16'h0000, 16'h0000);
        // Clear, then zero-length edges.
        send_item(psat_pkg::CMD_CLEAR, 16'hFFFF, 16'hFFFF);
        send_item(psat_pkg::CMD_TEST, 16'h0000, 16'h0000);
        send_item(psat_pkg::CMD_APPEND_B, 16'h0000, 16'h0000);
        send_item(psat_pkg::CMD_APPEND_B, 16'h0000, 16'h0000);
        send_item(psat_pkg::CMD_TEST, 16'h0000, 16'h0000);
        send_item(psat_pkg::CMD_APPEND_A, 16'h0000, 16'h0000);
        send_item(psat_pkg::CMD_TEST, 16'h0000, 16'h0000);
        // Clear once more, then disjoint extreme segments.
        send_item(psat_pkg::CMD_CLEAR, 16'h0000, 16'h0000);
        send_item(psat_pkg::CMD_APPEND_A, 16'h8000, 16'h8000);
        send_item(psat_pkg::CMD_APPEND_A, 16'h8000, 16'h7FFF);
        send_item(psat_pkg::CMD_APPEND_B, 16'h7FFF, 16'h7FFF);
        send_item(psat_pkg::CMD_APPEND_B, 16'h7FFF, 16'h8000);
        send_item(psat_pkg::CMD_TEST, 16'h5555, 16'hAAAA);
        drain();

        // Random sequences; every so often the sender waits for all results.
        while (items_done < TARGET_ITEMS) begin
            burst_mode = ($urandom_range(0, 4) == 0);
            kind       = $urandom_range(0, 9);
            case (kind)
                6:       run_overflow();
                7:       run_noise();
                8:       run_tiny();
                9:       run_overlap_pair(1'b1);
                default: run_overlap_pair(1'b0);
            endcase
            seq_count++;
            if (seq_count % 16 == 0) drain();
        end
        burst_mode = 1'b0;
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== polygon_sat_overlap_test_top.f =====
rtl/psat_pkg.sv
rtl/psat_front.sv
rtl/psat_queue.sv
rtl/psat_back.sv
rtl/polygon_sat_overlap_test_top.sv
dv/tb_top.sv
